// ===== rtl/msvba_pkg.sv =====
// ----------------------------------------------------------------------------
// msvba_pkg: shared types and constants for the vector block allocator
// Holds the request codes, result status codes, the controller state type
// and the command group passed from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package msvba_pkg;

    // Largest map the search tree is built for, and its number of levels.
    localparam int MAX_VECTORS = 64;
    localparam int LEVELS      = 7;

    // Field widths of one request and one result item.
    localparam int CMD_W   = 1;
    localparam int COUNT_W = 6;
    localparam int VEC_W   = 5;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 6;
    localparam int LVL_W   = 3;
    localparam int SPAN_W  = 7;

    // Request codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // capture the request fields and the block size
        logic exec;  // run the search, update the map, write the result
    } t_ctrl;

endpackage

`default_nettype wire

// ===== rtl/msvba_ctrl.sv =====
// ----------------------------------------------------------------------------
// msvba_ctrl: request sequencer for the vector block allocator
// Accepts a request, runs the execute step when the result register is
// free to be written, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module msvba_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    output msvba_pkg::t_ctrl o_ctrl
);

    msvba_pkg::t_state r_state;
    msvba_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_slot_free;

    // The result register may be written when empty or being drained now.
    assign w_slot_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            msvba_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = msvba_pkg::S_EXEC;
                end
            end
            msvba_pkg::S_EXEC: begin
                if (w_slot_free) begin
                    n_state = msvba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = msvba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready  = 1'b0;
        o_ctrl      = '0;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            msvba_pkg::S_IDLE: begin
                o_s_tready  = 1'b1;
                o_ctrl.load = i_s_tvalid;
            end
            msvba_pkg::S_EXEC: begin
                if (w_slot_free) begin
                    o_ctrl.exec = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msvba_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/msvba_dp.sv =====
// ----------------------------------------------------------------------------
// msvba_dp: in-use map and block search datapath
// Holds the in-use map, an AND tree of free flags for every aligned block
// size, the lowest-free-block search and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msvba_dp #(
    parameter int VECTORS = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  msvba_pkg::t_ctrl                   i_ctrl,
    input  wire  [msvba_pkg::CMD_W-1:0]        i_command,
    input  wire  [msvba_pkg::COUNT_W-1:0]      i_vector_count,
    input  wire  [msvba_pkg::VEC_W-1:0]        i_first_vector,
    output logic [msvba_pkg::STAT_W-1:0]       o_status,
    output logic [msvba_pkg::VEC_W-1:0]        o_base_vector,
    output logic [msvba_pkg::COUNT_W-1:0]      o_granted_count
);

    localparam logic [msvba_pkg::SPAN_W-1:0] VEC_LIMIT = msvba_pkg::SPAN_W'(VECTORS);

    // Captured request.
    logic [msvba_pkg::CMD_W-1:0]   r_cmd;
    logic [msvba_pkg::COUNT_W-1:0] r_cnt;
    logic [msvba_pkg::VEC_W-1:0]   r_first;
    logic [msvba_pkg::LVL_W-1:0]   r_lvl;
    logic [msvba_pkg::LVL_W-1:0]   n_lvl;

    logic [VECTORS-1:0] r_map;
    logic [VECTORS-1:0] n_map;

    logic [msvba_pkg::STAT_W-1:0]  r_status;
    logic [msvba_pkg::VEC_W-1:0]   r_base;
    logic [msvba_pkg::COUNT_W-1:0] r_granted;

    logic [msvba_pkg::LEVELS-1:0][msvba_pkg::MAX_VECTORS-1:0] w_free;
    logic [msvba_pkg::MAX_VECTORS-1:0] w_sel;
    logic                              w_found;
    logic [msvba_pkg::IDX_W-1:0]       w_idx;
    logic [msvba_pkg::SPAN_W-1:0]      w_size;
    logic [msvba_pkg::SPAN_W-1:0]      w_gn;
    logic [msvba_pkg::SPAN_W-1:0]      w_base;
    logic [msvba_pkg::SPAN_W-1:0]      w_set_end;
    logic [msvba_pkg::SPAN_W-1:0]      w_clr_end;
    logic [VECTORS-1:0]                w_set;
    logic [VECTORS-1:0]                w_clr;
    logic                              w_single;
    logic                              w_invalid;
    logic [msvba_pkg::COUNT_W-1:0]     w_cm1;

    // Block size exponent: ceil(log2(count)), zero for counts of zero or one.
    always_comb begin
        w_cm1 = i_vector_count - msvba_pkg::COUNT_W'(1);
        n_lvl = '0;
        if (i_vector_count > msvba_pkg::COUNT_W'(1)) begin
            for (int b = 0; b < msvba_pkg::COUNT_W; b++) begin
                if (w_cm1[b]) begin
                    n_lvl = msvba_pkg::LVL_W'(b + 1);
                end
            end
        end
    end

    // Free flags per aligned block; blocks reaching past the map read as used.
    always_comb begin
        w_free = '0;
        for (int i = 0; i < msvba_pkg::MAX_VECTORS; i++) begin
            if (i < VECTORS) begin
                w_free[0][i] = !r_map[i];
            end
        end
        for (int j = 1; j < msvba_pkg::LEVELS; j++) begin
            for (int i = 0; i < msvba_pkg::MAX_VECTORS / 2; i++) begin
                if (i < (msvba_pkg::MAX_VECTORS >> j)) begin
                    w_free[j][i] = w_free[j-1][2*i] && w_free[j-1][2*i+1];
                end
            end
        end
    end

    assign w_sel   = w_free[r_lvl];
    assign w_found = |w_sel;

    // Lowest free block at the selected size.
    always_comb begin
        w_idx = '0;
        for (int i = msvba_pkg::MAX_VECTORS - 1; i >= 0; i--) begin
            if (w_sel[i]) begin
                w_idx = msvba_pkg::IDX_W'(i);
            end
        end
    end

    assign w_single  = r_cnt <= msvba_pkg::COUNT_W'(1);
    assign w_size    = msvba_pkg::SPAN_W'(1) << r_lvl;
    assign w_invalid = !w_single && (w_size > VEC_LIMIT);
    assign w_gn      = w_single ? msvba_pkg::SPAN_W'(r_cnt) : w_size;
    assign w_base    = msvba_pkg::SPAN_W'(w_idx) << r_lvl;
    assign w_set_end = w_base + w_gn;
    assign w_clr_end = msvba_pkg::SPAN_W'(r_first) + msvba_pkg::SPAN_W'(r_cnt);

    always_comb begin
        for (int v = 0; v < VECTORS; v++) begin
            w_set[v] = (msvba_pkg::SPAN_W'(v) >= w_base)
                    && (msvba_pkg::SPAN_W'(v) < w_set_end);
            w_clr[v] = (msvba_pkg::SPAN_W'(v) >= msvba_pkg::SPAN_W'(r_first))
                    && (msvba_pkg::SPAN_W'(v) < w_clr_end);
        end
    end

    always_comb begin
        n_map = r_map;
        if (r_cmd == msvba_pkg::CMD_FREE) begin
            n_map = r_map & ~w_clr;
        end else if (!w_invalid && w_found) begin
            n_map = r_map | w_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_ctrl.exec) begin
            r_map <= n_map;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= i_command;
            r_cnt   <= i_vector_count;
            r_first <= i_first_vector;
            r_lvl   <= n_lvl;
        end
        if (i_ctrl.exec) begin
            r_status  <= msvba_pkg::ST_OK;
            r_base    <= '0;
            r_granted <= '0;
            if (r_cmd == msvba_pkg::CMD_ALLOC) begin
                if (w_invalid) begin
                    r_status <= msvba_pkg::ST_INVALID;
                end else if (!w_found) begin
                    r_status <= msvba_pkg::ST_NO_SPACE;
                end else begin
                    r_base    <= w_base[msvba_pkg::VEC_W-1:0];
                    r_granted <= w_gn[msvba_pkg::COUNT_W-1:0];
                end
            end
        end
    end

    assign o_status        = r_status;
    assign o_base_vector   = r_base;
    assign o_granted_count = r_granted;

endmodule

`default_nettype wire

// ===== rtl/msi_vector_block_allocator.sv =====
// A request is accepted in the idle state and its fields are registered; the
// execute state then runs the map search and update and registers the result.
// No new request is taken until the execute step has run. A waiting result
// does not stop the next request from being accepted, but holds its execute
// step until the result register is empty or being drained.
// Reset (synchronous, active low) clears the in-use map and the result valid.
// ----------------------------------------------------------------------------
// msi_vector_block_allocator: aligned power-of-two interrupt vector allocator
// Keeps a one-bit-per-vector in-use map. Allocate requests take the lowest
// free vector or the lowest naturally aligned free block of the rounded-up
// size; free requests clear a run of vectors without checks.
// ----------------------------------------------------------------------------
`default_nettype none

module msi_vector_block_allocator #(
    parameter int VECTORS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Request stream.
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [5:0] vector_count, [10:6] first_vector, rest zero
    input  wire  [0:0]  i_s_tuser,   // [0] command: 0 allocate, 1 free
    // Result stream.
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // [1:0] status, [6:2] base_vector,
                                     // [12:7] granted_count, rest zero
);

    // The controller decides when a request is captured and when the execute
    // step may run: only when the result register is empty or is being drained
    // in the same cycle, so no result is ever overwritten.
    msvba_pkg::t_ctrl w_ctrl;

    logic [msvba_pkg::STAT_W-1:0]  w_status;
    logic [msvba_pkg::VEC_W-1:0]   w_base_vector;
    logic [msvba_pkg::COUNT_W-1:0] w_granted_count;

    msvba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_ctrl     (w_ctrl)
    );

    // The datapath holds the map, the free-block tree and the result payload.
    // Counts of zero and one search single vectors; larger counts search the
    // tree level of the rounded-up power of two, where blocks that would run
    // past the end of the map are never reported free.
    msvba_dp #(
        .VECTORS (VECTORS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_command       (i_s_tuser),
        .i_vector_count  (i_s_tdata[5:0]),
        .i_first_vector  (i_s_tdata[10:6]),
        .o_status        (w_status),
        .o_base_vector   (w_base_vector),
        .o_granted_count (w_granted_count)
    );

    // The request bits above first_vector are padding and are not used.
    assign o_m_tdata = {3'b000, w_granted_count, w_base_vector, w_status};

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for msi_vector_block_allocator
// Drives allocate and free requests into the request stream and checks each
// result item against a behavioral model of the in-use vector map or a typed-in
// result. A short table of directed requests comes first, then constrained-by-hand
// random traffic with random idle bursts on both streams.
// ----------------------------------------------------------------------------

module testbench;

    localparam int VECTORS      = 32;
    localparam int RANDOM_ITEMS = 500;
    localparam int STEADY_ITEMS = 60;    // final random items sent with no idling
    localparam int STALL_LIMIT  = 1000;  // cycles with no item moving on either side
    localparam int NUM_ROWS     = 25;
    localparam bit ROW_CHECKED   = 1'b1; // row carries its own expected result
    localparam bit ROW_PREDICTED = 1'b0; // row is checked against the map model

    typedef struct packed {
        logic [msvba_pkg::STAT_W-1:0]  status;
        logic [msvba_pkg::VEC_W-1:0]   base;
        logic [msvba_pkg::COUNT_W-1:0] granted;
    } t_vector_grant;

    typedef struct packed {
        logic [msvba_pkg::CMD_W-1:0]   cmd;
        logic [msvba_pkg::COUNT_W-1:0] count;
        logic [msvba_pkg::VEC_W-1:0]   first;
        logic                          typed;
        t_vector_grant                 result;
    } t_request_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;    // [5:0] vector_count, [10:6] first_vector, rest zero
    logic [0:0]  i_s_tuser  = '0;    // [0] command
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;          // [1:0] status, [6:2] base_vector, [12:7] granted_count

    logic [VECTORS-1:0] vector_map;  // model of the in-use map, 1 = reserved
    t_vector_grant      pending_grants[$];
    t_request_row       directed_requests[NUM_ROWS];

    int mismatches     = 0;
    int results_seen   = 0;
    int idle_cycles    = 0;
    int grants         = 0;
    int oversize_fails = 0;
    int full_fails     = 0;
    int releases       = 0;
    bit steady_phase   = 1'b0;

    msi_vector_block_allocator #(
        .VECTORS    (VECTORS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one request to the map model and returns the result it gives.
    function automatic t_vector_grant allocate_or_release(
        input logic [msvba_pkg::CMD_W-1:0]   cmd,
        input logic [msvba_pkg::COUNT_W-1:0] count,
        input logic [msvba_pkg::VEC_W-1:0]   first
    );
        t_vector_grant r;
        int unsigned   blk;
        logic [63:0]   m;
        bit            found;
        r     = '{msvba_pkg::ST_OK, '0, '0};
        found = 1'b0;
        if (cmd == msvba_pkg::CMD_FREE) begin
            // Bits that fall past the top of the map are simply dropped.
            for (int i = 0; i < int'(count); i++) begin
                if (int'(first) + i < VECTORS) vector_map[int'(first) + i] = 1'b0;
            end
        end else if (count <= 1) begin
            // Zero reports the lowest free vector but reserves nothing.
            for (int v = 0; v < VECTORS; v++) begin
                if (!found && !vector_map[v]) begin
                    found  = 1'b1;
                    r.base = v[msvba_pkg::VEC_W-1:0];
                    r.granted = count;
                    if (count == 1) vector_map[v] = 1'b1;
                end
            end
            if (!found) r.status = msvba_pkg::ST_NO_SPACE;
        end else begin
            blk = 1;
            while (blk < count) blk = blk << 1;
            if (blk > VECTORS) begin
                r.status = msvba_pkg::ST_INVALID;
            end else begin
                for (int unsigned b = 0; b + blk <= VECTORS; b += blk) begin
                    m = ((64'd1 << blk) - 64'd1) << b;
                    if (!found && (vector_map & m[VECTORS-1:0]) == '0) begin
                        found      = 1'b1;
                        vector_map = vector_map | m[VECTORS-1:0];
                        r.base     = b[msvba_pkg::VEC_W-1:0];
                        r.granted  = blk[msvba_pkg::COUNT_W-1:0];
                    end
                end
                if (!found) r.status = msvba_pkg::ST_NO_SPACE;
            end
        end
        return r;
    endfunction

    // Request sizes lean toward small blocks so the map fills and drains often.
    function automatic logic [msvba_pkg::COUNT_W-1:0] pick_count();
        int unsigned r;
        int unsigned c;
        r = $urandom_range(0, 99);
        if (r < 5)       c = 0;
        else if (r < 50) c = $urandom_range(1, 4);
        else if (r < 82) c = $urandom_range(5, 16);
        else if (r < 92) c = $urandom_range(17, 32);
        else             c = $urandom_range(33, 63);
        return c[msvba_pkg::COUNT_W-1:0];
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 results_seen, field, got, want);
        mismatches++;
    endtask

    // Presents one request item, waits for it to be taken, and queues the
    // result it should produce. Valid stays high when the next item follows
    // without a gap.
    task automatic send_request(
        input logic [msvba_pkg::CMD_W-1:0]   cmd,
        input logic [msvba_pkg::COUNT_W-1:0] count,
        input logic [msvba_pkg::VEC_W-1:0]   first,
        input logic                          typed,
        input t_vector_grant                 typed_result
    );
        t_vector_grant predicted;
        t_vector_grant want;
        int            gap;
        @(negedge i_clk);
        if (!steady_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, first, count};
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = allocate_or_release(cmd, count, first);
        want      = typed ? typed_result : predicted;
        pending_grants.push_back(want);
        if (cmd == msvba_pkg::CMD_FREE)                releases++;
        else if (want.status == msvba_pkg::ST_OK)      grants++;
        else if (want.status == msvba_pkg::ST_INVALID) oversize_fails++;
        else                                           full_fails++;
    endtask

    // Result side: random back-pressure bursts until the final stretch.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0 && !steady_phase) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
                if (!steady_phase && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 12);
            end
        end
    end

    // Compare every result item with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_vector_grant want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_grants.size() == 0) begin
                $display("unexpected result item: tdata %h", o_m_tdata);
                mismatches++;
            end else begin
                want = pending_grants.pop_front();
                if (o_m_tdata[1:0] !== want.status)
                    report_mismatch("status", o_m_tdata[1:0], want.status);
                if (o_m_tdata[6:2] !== want.base)
                    report_mismatch("base_vector", o_m_tdata[6:2], want.base);
                if (o_m_tdata[12:7] !== want.granted)
                    report_mismatch("granted_count", o_m_tdata[12:7], want.granted);
                if (o_m_tdata[15:13] !== 3'b000)
                    report_mismatch("pad bits", o_m_tdata[15:13], 0);
            end
            results_seen++;
        end
    end

    // Ends the run if the block stops moving items for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [msvba_pkg::CMD_W-1:0]   cmd;
        logic [msvba_pkg::COUNT_W-1:0] count;
        logic [msvba_pkg::VEC_W-1:0]   first;

        // Directed requests, starting from an empty map. Results are typed in
        // where they follow directly from reset, a full or empty map, or an
        // oversize count; the rest come from the model.
        directed_requests = '{
            '{msvba_pkg::CMD_ALLOC, 6'd1, 5'd0, ROW_CHECKED, '{msvba_pkg::ST_OK, 5'd0, 6'd1}},
            '{msvba_pkg::CMD_ALLOC, 6'd0, 5'd31, ROW_CHECKED, '{msvba_pkg::ST_OK, 5'd1, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd2, 5'd0, ROW_PREDICTED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd3, 5'd17, ROW_PREDICTED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd33, 5'd0, ROW_CHECKED,
              '{msvba_pkg::ST_INVALID, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd63, 5'd31, ROW_CHECKED,
              '{msvba_pkg::ST_INVALID, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd32, 5'd0, ROW_CHECKED,
              '{msvba_pkg::ST_NO_SPACE, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd8, 5'd10, ROW_PREDICTED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_FREE, 6'd63, 5'd0, ROW_CHECKED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd32, 5'd0, ROW_CHECKED, '{msvba_pkg::ST_OK, 5'd0, 6'd32}},
            '{msvba_pkg::CMD_ALLOC, 6'd1, 5'd0, ROW_CHECKED,
              '{msvba_pkg::ST_NO_SPACE, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd0, 5'd0, ROW_CHECKED,
              '{msvba_pkg::ST_NO_SPACE, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd2, 5'd0, ROW_CHECKED,
              '{msvba_pkg::ST_NO_SPACE, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_FREE, 6'd1, 5'd31, ROW_CHECKED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd0, 5'd0, ROW_PREDICTED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd1, 5'd0, ROW_PREDICTED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_FREE, 6'd20, 5'd16, ROW_CHECKED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd16, 5'd0, ROW_PREDICTED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_FREE, 6'd63, 5'd31, ROW_CHECKED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_FREE, 6'd0, 5'd5, ROW_CHECKED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd5, 5'd0, ROW_PREDICTED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd17, 5'd0, ROW_PREDICTED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_FREE, 6'd32, 5'd0, ROW_CHECKED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}},
            '{msvba_pkg::CMD_ALLOC, 6'd17, 5'd0, ROW_CHECKED, '{msvba_pkg::ST_OK, 5'd0, 6'd32}},
            '{msvba_pkg::CMD_FREE, 6'd42, 5'd21, ROW_CHECKED, '{msvba_pkg::ST_OK, 5'd0, 6'd0}}
        };

        vector_map = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_requests[k])
            send_request(directed_requests[k].cmd, directed_requests[k].count,
                         directed_requests[k].first, directed_requests[k].typed,
                         directed_requests[k].result);

        // Random traffic: a mix of allocations and random-sized frees, with an
        // occasional full release so the map keeps cycling between empty
        // and crowded.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_phase = (n >= RANDOM_ITEMS - STEADY_ITEMS);
            first = msvba_pkg::VEC_W'($urandom_range(0, 31));
            if ($urandom_range(0, 99) < 55) begin
                cmd   = msvba_pkg::CMD_ALLOC;
                count = pick_count();
            end else begin
                cmd = msvba_pkg::CMD_FREE;
                if ($urandom_range(0, 9) == 0) begin
                    first = '0;
                    count = msvba_pkg::COUNT_W'($urandom_range(32, 63));
                end else begin
                    count = pick_count();
                end
            end
            send_request(cmd, count, first, ROW_PREDICTED, '{msvba_pkg::ST_OK, 5'd0, 6'd0});
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Checked %0d results: %0d allocations granted, %0d oversize and %0d no-space",
                 results_seen, grants, oversize_fails, full_fails);
        $display("rejections, %0d free requests; %0d mismatches.", releases, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
